// ----- rtl/bitmask_run_range_packer_defines.svh -----
// assertion macros for the bitmask run range packer checker
`ifndef BITMASK_RUN_RANGE_PACKER_DEFINES_SVH
`define BITMASK_RUN_RANGE_PACKER_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define BMRP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BMRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bmrp_pkg.sv -----
// shared types and constants for the bitmask run range packer
package bmrp_pkg;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;   // bit position inside a mask word
  localparam int CNT_W   = 6;   // trailing-zero count, 0..32
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 9;

  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic [INDEX_W-1:0] source_index;
    logic [LEN_W-1:0]   run_length;
    logic               last_range;
  } result_t;

endpackage

// ----- rtl/bitmask_run_range_packer.sv -----
// top level of the bitmask run range packer: run sequencer and range state
//
// Takes one 32-bit use-mask word per input transaction and emits one result
// transaction per maximal run of set bits: source index (bit position plus
// 32 times the word number), tightly packed destination index and run length.
// A run starting at bit 0 that continues the held range merges into it; the
// newest range is held back until it can no longer grow and goes out with
// last_range set when the final word arrives (a zero-length end marker if the
// layout had no set bit at all). One shared trailing-zero counter does all the
// scanning: a find-start state locates a run start, a find-end state its end.
// in_stall stays high while a word is scanned, and also while the sequencer
// waits on out_stall to hand a range to the single output register. After
// reset no clearing is needed; the block can take a word once reset is low.
module bitmask_run_range_packer #(
  parameter int MAX_WORDS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bmrp_pkg::WORD_W-1:0]  mask_word,
  input  logic                         final_word,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bmrp_pkg::INDEX_W-1:0] dest_index,
  output logic [bmrp_pkg::INDEX_W-1:0] source_index,
  output logic [bmrp_pkg::LEN_W-1:0]   run_length,
  output logic                         last_range
);

  localparam int WN_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND_START,
    ST_FIND_END,
    ST_FINISH
  } state_t;

  state_t state, state_next;

  // word in progress, consumed bits cleared as runs are taken
  logic [bmrp_pkg::WORD_W-1:0]  work, work_next;
  logic                         fin, fin_next;
  logic [bmrp_pkg::POS_W-1:0]   start, start_next;

  // range state carried across words
  logic [WN_W-1:0]              word_number, word_number_next;
  logic [bmrp_pkg::LEN_W-1:0]   next_dest, next_dest_next;
  logic [bmrp_pkg::INDEX_W-1:0] held_source, held_source_next;
  logic [bmrp_pkg::INDEX_W-1:0] held_dest, held_dest_next;
  logic [bmrp_pkg::LEN_W-1:0]   held_length, held_length_next;
  logic                         held_valid, held_valid_next;

  // shared scanner
  logic [bmrp_pkg::WORD_W-1:0]  ctz_word;
  logic [bmrp_pkg::CNT_W-1:0]   ctz_count;

  // output register handoff
  logic                         emit;
  bmrp_pkg::result_t            emit_data;
  logic                         out_free;

  // run arithmetic
  logic [WN_W+4:0]              base_full;
  logic [bmrp_pkg::LEN_W-1:0]   base9;
  logic [bmrp_pkg::CNT_W-1:0]   len;
  logic                         merge;

  assign in_stall  = (state != ST_IDLE);
  assign base_full = {word_number, 5'b0};
  assign base9     = bmrp_pkg::LEN_W'(base_full);
  assign len       = ctz_count - {1'b0, start};

  // a run at bit 0 extends the held range when that range ends exactly here
  assign merge = held_valid && (start == '0) && (word_number != '0) &&
                 (bmrp_pkg::LEN_W'({1'b0, held_source} + held_length) == base9);

  // start search looks for a one; end search looks for a zero at or above start
  assign ctz_word = (state == ST_FIND_END) ?
                    (~work & ({bmrp_pkg::WORD_W{1'b1}} << start)) : work;

  bmrp_ctz u_ctz (
    .word  (ctz_word),
    .count (ctz_count)
  );

  always_comb begin
    state_next       = state;
    work_next        = work;
    fin_next         = fin;
    start_next       = start;
    word_number_next = word_number;
    next_dest_next   = next_dest;
    held_source_next = held_source;
    held_dest_next   = held_dest;
    held_length_next = held_length;
    held_valid_next  = held_valid;
    emit             = 1'b0;
    emit_data        = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          work_next  = mask_word;
          fin_next   = final_word;
          state_next = ST_FIND_START;
        end
      end

      ST_FIND_START: begin
        if (work == '0) begin
          state_next = ST_FINISH;
        end else begin
          start_next = ctz_count[bmrp_pkg::POS_W-1:0];
          state_next = ST_FIND_END;
        end
      end

      ST_FIND_END: begin
        if (merge) begin
          held_length_next = held_length + bmrp_pkg::LEN_W'(len);
          next_dest_next   = next_dest + bmrp_pkg::LEN_W'(len);
          work_next        = work & ({bmrp_pkg::WORD_W{1'b1}} << ctz_count);
          state_next       = ST_FIND_START;
        end else if (!held_valid || out_free) begin
          // close the held range and open a new one
          emit                   = held_valid;
          emit_data.dest_index   = held_dest;
          emit_data.source_index = held_source;
          emit_data.run_length   = held_length;
          emit_data.last_range   = 1'b0;
          held_source_next = base9[bmrp_pkg::INDEX_W-1:0] +
                             bmrp_pkg::INDEX_W'(start);
          held_dest_next   = next_dest[bmrp_pkg::INDEX_W-1:0];
          held_length_next = bmrp_pkg::LEN_W'(len);
          held_valid_next  = 1'b1;
          next_dest_next   = next_dest + bmrp_pkg::LEN_W'(len);
          work_next        = work & ({bmrp_pkg::WORD_W{1'b1}} << ctz_count);
          state_next       = ST_FIND_START;
        end
      end

      ST_FINISH: begin
        if (!fin) begin
          // word counter wraps after the last allowed word
          if (word_number == WN_W'(MAX_WORDS - 1)) begin
            word_number_next = '0;
          end else begin
            word_number_next = word_number + 1'b1;
          end
          state_next = ST_IDLE;
        end else if (out_free) begin
          // final range, or the empty end marker when nothing was found
          emit                   = 1'b1;
          emit_data.dest_index   = held_valid ? held_dest : '0;
          emit_data.source_index = held_valid ? held_source : '0;
          emit_data.run_length   = held_valid ? held_length : '0;
          emit_data.last_range   = 1'b1;
          word_number_next = '0;
          next_dest_next   = '0;
          held_source_next = '0;
          held_dest_next   = '0;
          held_length_next = '0;
          held_valid_next  = 1'b0;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      word_number <= '0;
      next_dest   <= '0;
      held_source <= '0;
      held_dest   <= '0;
      held_length <= '0;
      held_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      word_number <= word_number_next;
      next_dest   <= next_dest_next;
      held_source <= held_source_next;
      held_dest   <= held_dest_next;
      held_length <= held_length_next;
      held_valid  <= held_valid_next;
    end
    work  <= work_next;
    fin   <= fin_next;
    start <= start_next;
  end

  bmrp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .load_data    (emit_data),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dest_index   (dest_index),
    .source_index (source_index),
    .run_length   (run_length),
    .last_range   (last_range)
  );

endmodule

// ----- rtl/bmrp_ctz.sv -----
// shared trailing-zero counter, returns 32 for an all-zero word
module bmrp_ctz (
  input  logic [bmrp_pkg::WORD_W-1:0] word,
  output logic [bmrp_pkg::CNT_W-1:0]  count
);

  always_comb begin
    count = bmrp_pkg::CNT_W'(bmrp_pkg::WORD_W);
    for (int i = bmrp_pkg::WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        count = bmrp_pkg::CNT_W'(i);
      end
    end
  end

endmodule

// ----- rtl/bmrp_out_reg.sv -----
// result output register between the sequencer and the downstream side
module bmrp_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  bmrp_pkg::result_t           load_data,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bmrp_pkg::INDEX_W-1:0] dest_index,
  output logic [bmrp_pkg::INDEX_W-1:0] source_index,
  output logic [bmrp_pkg::LEN_W-1:0]   run_length,
  output logic                        last_range
);

  bmrp_pkg::result_t held;

  // a slot is free when empty or being drained this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      held <= load_data;
    end
  end

  assign dest_index   = held.dest_index;
  assign source_index = held.source_index;
  assign run_length   = held.run_length;
  assign last_range   = held.last_range;

endmodule

// ----- rtl/bmrp_checker.sv -----
// port-level checks for the bitmask run range packer, bound to the top level
`include "bitmask_run_range_packer_defines.svh"

module bmrp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bmrp_pkg::INDEX_W-1:0] dest_index,
  input logic [bmrp_pkg::INDEX_W-1:0] source_index,
  input logic [bmrp_pkg::LEN_W-1:0]   run_length,
  input logic                         last_range
);

  // a taken word always keeps the block busy for at least the next cycle
  `BMRP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "word taken while idle cycle expected busy")

  // only the end marker may carry a zero length
  `BMRP_ASSERT_ALWAYS(a_zero_len_is_last, !out_valid || run_length != '0 || last_range, "zero-length range without last flag")

  // empty end marker has all-zero indices
  `BMRP_ASSERT_ALWAYS(a_marker_zero_idx, !out_valid || run_length != '0 || (dest_index == '0 && source_index == '0), "end marker with nonzero index")

  // stalled result holds
  `BMRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dest_index) && $stable(source_index) && $stable(run_length) && $stable(last_range), "stalled result changed")

endmodule

bind bitmask_run_range_packer bmrp_checker u_bmrp_checker (.*);

// ----- tb/bitmask_run_range_packer_test.sv -----
// self-checking testbench for the bitmask run range packer: queued driver, range predictor, checker
`timescale 1ns / 100ps

module bitmask_run_range_packer_test;

  localparam int WORD_LIMIT = 8;

  // one mask word as offered on the input channel
  typedef struct packed {
    logic [bmrp_pkg::WORD_W-1:0] mask;
    logic                        fin;
  } mask_item_t;

  logic clk;
  logic rst = 1'b1;

  logic                         in_valid   = 1'b0;
  logic                         in_stall;
  logic [bmrp_pkg::WORD_W-1:0]  mask_word  = '0;
  logic                         final_word = 1'b0;
  logic                         out_valid;
  logic                         out_stall  = 1'b0;
  logic [bmrp_pkg::INDEX_W-1:0] dest_index;
  logic [bmrp_pkg::INDEX_W-1:0] source_index;
  logic [bmrp_pkg::LEN_W-1:0]   run_length;
  logic                         last_range;

  mask_item_t         pending_words[$];   // words still to be offered
  bmrp_pkg::result_t  expected_ranges[$]; // ranges predicted but not yet seen
  mask_item_t         offered_word;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;

  // predictor copy of the packing state
  int unsigned                  layout_word = 0;
  logic [bmrp_pkg::LEN_W-1:0]   packed_next = '0;
  logic [bmrp_pkg::INDEX_W-1:0] open_src    = '0;
  logic [bmrp_pkg::INDEX_W-1:0] open_dst    = '0;
  logic [bmrp_pkg::LEN_W-1:0]   open_len    = '0;
  logic                         open_valid  = 1'b0;

  bitmask_run_range_packer #(
    .MAX_WORDS(WORD_LIMIT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mask_word   (mask_word),
    .final_word  (final_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dest_index  (dest_index),
    .source_index(source_index),
    .run_length  (run_length),
    .last_range  (last_range)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // append one range to the expected list
  task automatic push_range(input logic [bmrp_pkg::INDEX_W-1:0] dst,
                            input logic [bmrp_pkg::INDEX_W-1:0] src,
                            input logic [bmrp_pkg::LEN_W-1:0] len, input logic last);
    bmrp_pkg::result_t r;
    begin
      r.dest_index   = dst;
      r.source_index = src;
      r.run_length   = len;
      r.last_range   = last;
      expected_ranges = {expected_ranges, r};
    end
  endtask

  // scan one mask word, emit the ranges it closes and update the held range
  task automatic predict_ranges(input logic [bmrp_pkg::WORD_W-1:0] mask, input logic fin);
    int unsigned                pos;
    int unsigned                first;
    int unsigned                len;
    logic [bmrp_pkg::LEN_W-1:0] base;
    logic [bmrp_pkg::LEN_W-1:0] open_end;
    begin
      base = bmrp_pkg::LEN_W'(32 * layout_word);
      pos  = 0;
      while (pos < bmrp_pkg::WORD_W) begin
        if (mask[pos]) begin
          first = pos;
          while (pos < bmrp_pkg::WORD_W && mask[pos]) pos++;
          len = pos - first;
          open_end = open_src + open_len;
          // a run at bit 0 that picks up exactly where the held range stops grows it
          if (open_valid && first == 0 && layout_word != 0 && open_end == base) begin
            open_len = open_len + bmrp_pkg::LEN_W'(len);
          end else begin
            if (open_valid) push_range(open_dst, open_src, open_len, 1'b0);
            open_src   = base[bmrp_pkg::INDEX_W-1:0] + bmrp_pkg::INDEX_W'(first);
            open_dst   = packed_next[bmrp_pkg::INDEX_W-1:0];
            open_len   = bmrp_pkg::LEN_W'(len);
            open_valid = 1'b1;
          end
          packed_next = packed_next + bmrp_pkg::LEN_W'(len);
        end else begin
          pos++;
        end
      end
      if (fin) begin
        // held range closes the layout, or a zero-length marker if nothing was used
        if (open_valid) push_range(open_dst, open_src, open_len, 1'b1);
        else push_range('0, '0, '0, 1'b1);
        layout_word = 0;
        packed_next = '0;
        open_src    = '0;
        open_dst    = '0;
        open_len    = '0;
        open_valid  = 1'b0;
      end else begin
        layout_word = (layout_word == WORD_LIMIT - 1) ? 0 : layout_word + 1;
      end
    end
  endtask

  task automatic push_word(input logic [bmrp_pkg::WORD_W-1:0] m, input logic f);
    mask_item_t it;
    begin
      it.mask = m;
      it.fin  = f;
      pending_words = {pending_words, it};
    end
  endtask

  // mask mix: random words, edge patterns, single runs, maximum run count
  function automatic logic [bmrp_pkg::WORD_W-1:0] pick_mask();
    int unsigned off;
    int unsigned len;
    logic [63:0] field;
    logic [bmrp_pkg::WORD_W-1:0] m;
    begin
      case ($urandom_range(9))
        0: m = '0;
        1: m = '1;
        2: m = ($urandom_range(1) != 0) ? 32'h5555_5555 : 32'hAAAA_AAAA;
        3: m = $urandom() | 32'h8000_0001;  // touches both word edges
        4: m = 32'h1 << $urandom_range(31);
        5, 6: begin
          off   = $urandom_range(31);
          len   = $urandom_range(1, 32);
          field = ((64'd1 << len) - 64'd1) << off;
          m     = field[bmrp_pkg::WORD_W-1:0];
        end
        default: m = $urandom();
      endcase
      pick_mask = m;
    end
  endfunction

  // random layouts, mostly closed by a final word, a few running past the word limit
  task automatic queue_layouts(input int unsigned n_items);
    int unsigned queued;
    int unsigned n_words;
    int unsigned w;
    bit          closes;
    begin
      queued = 0;
      while (queued < n_items) begin
        case ($urandom_range(9))
          0:       n_words = $urandom_range(WORD_LIMIT + 1, WORD_LIMIT + 3);
          1, 2:    n_words = $urandom_range(5, WORD_LIMIT);
          default: n_words = $urandom_range(1, 4);
        endcase
        closes = ($urandom_range(9) != 0);
        for (w = 0; w < n_words; w++)
          push_word(pick_mask(), closes && (w == n_words - 1));
        queued += n_words;
      end
    end
  endtask

  // sender stays quiet until every queued word is taken and every range has come back
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_ranges.size() != 0)
      @(negedge clk);
  endtask

  // driver: a new word goes out only when the slot is free; a stalled word is held.
  // the prediction is made when the word is first offered, which is safe since an
  // offered word cannot change and is always taken in order
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_word = pending_words.pop_front();
        predict_ranges(offered_word.mask, offered_word.fin);
        in_valid   <= 1'b1;
        mask_word  <= offered_word.mask;
        final_word <= offered_word.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: every result transaction is matched against the oldest predicted range
  always @(posedge clk) begin
    bmrp_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ranges.size() == 0) begin
        $display("%0t: unexpected range dst=%0d src=%0d len=%0d last=%0d", $time,
                 dest_index, source_index, run_length, last_range);
        error_count++;
      end else begin
        want = expected_ranges.pop_front();
        if (dest_index !== want.dest_index) begin
          $display("%0t: dest_index expected %0d actual %0d", $time,
                   want.dest_index, dest_index);
          error_count++;
        end
        if (source_index !== want.source_index) begin
          $display("%0t: source_index expected %0d actual %0d", $time,
                   want.source_index, source_index);
          error_count++;
        end
        if (run_length !== want.run_length) begin
          $display("%0t: run_length expected %0d actual %0d", $time,
                   want.run_length, run_length);
          error_count++;
        end
        if (last_range !== want.last_range) begin
          $display("%0t: last_range expected %0d actual %0d", $time,
                   want.last_range, last_range);
          error_count++;
        end
      end
    end
  end

  // run watchdog
  initial begin
    #2_000_000;
    $display("bitmask_run_range_packer_test: errors");
    $finish;
  end

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, no idling on either side
    push_word(32'h0000_0000, 1'b1);           // empty layout gives the end marker
    push_word(32'hFFFF_FFFF, 1'b1);           // one full-word range
    push_word(32'h0000_0001, 1'b0);           // held range, then sixteen runs
    push_word(32'hAAAA_AAAA, 1'b1);
    push_word(32'h8000_0000, 1'b0);           // run crossing two word boundaries
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_0001, 1'b1);
    for (i = 0; i < WORD_LIMIT; i++)          // longest possible range
      push_word(32'hFFFF_FFFF, i == WORD_LIMIT - 1);
    for (i = 0; i <= WORD_LIMIT; i++)         // word count wraps, no merge across it
      push_word(32'hFFFF_FFFF, i == WORD_LIMIT);
    wait_drained();

    send_idle_pct  = 83;
    recv_stall_pct = 0;
    queue_layouts(20);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    queue_layouts(20);
    wait_drained();

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    queue_layouts(20);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_layouts(18);
    wait_drained();

    // let a word still being scanned finish, any stray result is caught by the monitor
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("bitmask_run_range_packer_test: clean");
    end else begin
      $display("bitmask_run_range_packer_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bmrp_pkg.sv
rtl/bmrp_ctz.sv
rtl/bmrp_out_reg.sv
rtl/bitmask_run_range_packer.sv
rtl/bmrp_checker.sv
tb/bitmask_run_range_packer_test.sv
